// ===== hw/rtl/stq_pkg.sv =====
// Shared types, codes and constants of the sorted timer queue engine.
package stq_pkg;

  localparam int unsigned NumTimersDefault = 16;
  localparam logic [15:0] MaxSleepReset = 16'd55000;
  localparam logic [15:0] MaxSleepLimit = 16'd55000;
  localparam logic [16:0] RtcWrap = 17'd60000;

  localparam logic [2:0] OpCreate = 3'd0;
  localparam logic [2:0] OpRemove = 3'd1;
  localparam logic [2:0] OpStart  = 3'd2;
  localparam logic [2:0] OpStop   = 3'd3;
  localparam logic [2:0] OpSync   = 3'd4;

  localparam logic [1:0] StFree    = 2'd0;
  localparam logic [1:0] StCreated = 2'd1;
  localparam logic [1:0] StRunning = 2'd2;

  localparam logic [1:0] WakeNone = 2'd0;
  localparam logic [1:0] WakeSet  = 2'd1;
  localparam logic [1:0] WakeFire = 2'd2;
  localparam logic [1:0] WakeStop = 2'd3;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // latch the input item
    logic create;      // claim lowest free slot
    logic calc_elapsed;
    logic walk_init;   // cursor <= head
    logic sub_step;    // subtract at cursor, advance
    logic load_tmo;    // time_left[id] <= timeout
    logic deq;         // unlink id (status is checked)
    logic set_free;
    logic enq_init;    // compare with head, begin search
    logic enq_step;    // advance search one node
    logic enq_link;    // write links after search
    logic wake_eval;   // compute wake action from head
    logic done;        // present result
  } stq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] op;
    logic       id_ok;
    logic       was_created;
    logic       walk_end;
    logic       enq_direct;  // enqueue finished at init
    logic       search_end;
  } stq_sts_t;

endpackage

// ===== hw/rtl/sorted_timer_queue_engine.sv =====
// Top level of the sorted timer queue engine.
// Keeps a table of software timers; running ones sit in a list sorted by
// milliseconds left. Issue one item by holding operation_i, timer_id_i,
// timeout_ms_i and rtc_time_ms_i with start high while busy is low.
// One result per item is shown for a single cycle with done_o high:
// ok_o, allocated_id_o, wake_action_o, wake_ms_o, head_id_o.
// Create and rejected items go from decode straight to the result; remove and
// stop first unlink the timer; time sync ages every running timer in a walk
// of the sorted list; start unlinks, ages the list, loads the timeout and,
// when the slot is created, searches the sorted list for its place. The list
// walks visit one node per cycle. busy stays high until the result cycle ends.
// The max_sleep_ms register is written over cfg_valid_i/cfg_ready_o; the user
// must write it only when idle, which the block itself does not enforce.
// Reset empties the list, frees every slot, clears the last RTC time and
// loads max_sleep_ms with 55000. The receiver cannot stall results.
module sorted_timer_queue_engine import stq_pkg::*; #(
  parameter int unsigned NumTimers = NumTimersDefault,
  parameter int unsigned IdW = $clog2(NumTimers + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  logic [2:0]     operation_i,
  input  logic [3:0]     timer_id_i,
  input  logic [30:0]    timeout_ms_i,
  input  logic [15:0]    rtc_time_ms_i,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i,
  output logic           done_o,
  output logic           ok_o,
  output logic [IdW-1:0] allocated_id_o,
  output logic [1:0]     wake_action_o,
  output logic [15:0]    wake_ms_o,
  output logic [IdW-1:0] head_id_o
);

  stq_cmd_t cmd;
  stq_sts_t sts;
  logic [15:0] max_sleep_q;
  logic done_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_sleep_q <= MaxSleepReset;
      done_q <= 1'b0;
    end else begin
      if (cfg_valid_i) max_sleep_q <= cfg_data_i;
      done_q <= cmd.done;
    end
  end

  stq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .sts_i(sts), .cmd_o(cmd)
  );

  stq_datapath #(.NumTimers(NumTimers), .IdW(IdW)) u_dp (
    .clk_i, .rst_ni, .operation_i, .timer_id_i, .timeout_ms_i, .rtc_time_ms_i,
    .max_sleep_q_i(max_sleep_q), .cmd_i(cmd), .sts_o(sts), .ok_o,
    .allocated_id_o, .wake_action_o, .wake_ms_o, .head_id_o
  );

  assign done_o = cmd.done;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !done_o) else $error("done held two cycles");

endmodule

// ===== hw/rtl/stq_ctrl.sv =====
// Controller state machine of the sorted timer queue engine.
module stq_ctrl import stq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  stq_sts_t sts_i,
  output stq_cmd_t cmd_o
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SDecode = 4'd1;
  localparam logic [3:0] SDeq    = 4'd2;
  localparam logic [3:0] SElap   = 4'd3;
  localparam logic [3:0] SWalk   = 4'd4;
  localparam logic [3:0] SLoad   = 4'd5;
  localparam logic [3:0] SEnqI   = 4'd6;
  localparam logic [3:0] SEnqS   = 4'd7;
  localparam logic [3:0] SEnqL   = 4'd8;
  localparam logic [3:0] SDone   = 4'd9;
  localparam logic [3:0] SWake   = 4'd10;

  logic [3:0] state_q, state_d;
  logic       start_op_q, start_op_d;

  assign busy = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    start_op_d = start_op_q;
    cmd_o = '0;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = SDecode;
        end
      end
      SDecode: begin
        start_op_d = 1'b0;
        if (sts_i.op == OpCreate) begin
          cmd_o.create = 1'b1;
          state_d = SDone;
        end else if (sts_i.op == OpSync) begin
          state_d = SElap;
        end else if ((sts_i.op == OpRemove || sts_i.op == OpStart ||
                      sts_i.op == OpStop) && sts_i.id_ok) begin
          start_op_d = (sts_i.op == OpStart);
          state_d = SDeq;
        end else begin
          state_d = SDone;
        end
      end
      SDeq: begin
        cmd_o.deq = 1'b1;
        if (sts_i.op == OpRemove) cmd_o.set_free = 1'b1;
        state_d = (sts_i.op == OpStart) ? SElap : SDone;
      end
      SElap: begin
        cmd_o.calc_elapsed = 1'b1;
        cmd_o.walk_init = 1'b1;
        state_d = SWalk;
      end
      SWalk: begin
        if (sts_i.walk_end) begin
          state_d = start_op_q ? SLoad : SDone;
        end else begin
          cmd_o.sub_step = 1'b1;
        end
      end
      SLoad: begin
        cmd_o.load_tmo = 1'b1;
        state_d = sts_i.was_created ? SEnqI : SDone;
      end
      SEnqI: begin
        cmd_o.enq_init = 1'b1;
        state_d = sts_i.enq_direct ? SWake : SEnqS;
      end
      SEnqS: begin
        if (sts_i.search_end) state_d = SEnqL;
        else cmd_o.enq_step = 1'b1;
      end
      SEnqL: begin
        cmd_o.enq_link = 1'b1;
        state_d = SDone;
      end
      SWake: begin
        cmd_o.wake_eval = 1'b1;
        state_d = SDone;
      end
      SDone: begin
        cmd_o.done = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      start_op_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_op_q <= start_op_d;
    end
  end

  a_done_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.done |-> busy) else $error("done while idle");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.done |=> !busy) else $error("busy after done");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> busy) else $error("load did not start work");

endmodule

// ===== hw/rtl/stq_datapath.sv =====
// Timer table, linked list and result registers of the timer queue engine.
module stq_datapath import stq_pkg::*; #(
  parameter int unsigned NumTimers = NumTimersDefault,
  parameter int unsigned IdW = $clog2(NumTimers + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [2:0]      operation_i,
  input  logic [3:0]      timer_id_i,
  input  logic [30:0]     timeout_ms_i,
  input  logic [15:0]     rtc_time_ms_i,
  input  logic [15:0]     max_sleep_q_i,
  input  stq_cmd_t        cmd_i,
  output stq_sts_t        sts_o,
  output logic            ok_o,
  output logic [IdW-1:0]  allocated_id_o,
  output logic [1:0]      wake_action_o,
  output logic [15:0]     wake_ms_o,
  output logic [IdW-1:0]  head_id_o
);

  localparam int unsigned IxW = $clog2(NumTimers);
  localparam logic [IdW-1:0] NoId = IdW'(NumTimers);
  localparam logic [IdW:0] WalkMax = (IdW+1)'(NumTimers);

  logic [1:0]     status_q [NumTimers];
  logic [31:0]    left_q   [NumTimers];
  logic [IdW-1:0] next_q   [NumTimers];
  logic [IdW-1:0] prev_q   [NumTimers];
  logic [IdW-1:0] head_q;
  logic [15:0]    last_q;

  logic [2:0]     op_q;
  logic [3:0]     id_q;
  logic [30:0]    tmo_q;
  logic [15:0]    rtc_q;
  logic           ok_q;
  logic [IdW-1:0] alloc_q;
  logic [1:0]     wact_q;
  logic [15:0]    wms_q;
  logic [15:0]    elap_q;
  logic [IdW-1:0] cur_q;     // walk cursor, also search nxt
  logic [IdW-1:0] prv_q;
  logic [IdW:0]   cnt_q;

  logic [IxW-1:0] idx;
  logic [IxW-1:0] cur_ix;
  logic           cur_valid;
  logic [IxW-1:0] free_ix;
  logic           free_found;
  logic [16:0]    el_sum;

  assign idx = IxW'(id_q);
  assign cur_ix = IxW'(cur_q);
  assign cur_valid = (cur_q < NoId);

  function automatic logic s_less(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  always_comb begin
    free_found = 1'b0;
    free_ix = '0;
    for (int i = NumTimers - 1; i >= 0; i--) begin
      if (status_q[i] == StFree) begin
        free_found = 1'b1;
        free_ix = IxW'(i);
      end
    end
  end

  always_comb begin
    if (last_q <= rtc_q) el_sum = {1'b0, rtc_q} - {1'b0, last_q};
    else el_sum = {1'b0, rtc_q} + RtcWrap - {1'b0, last_q};
  end

  // Wake evaluation for a given head.
  function automatic void wake_of(input logic [IdW-1:0] h, input logic [31:0] v,
                                  input logic [15:0] ms, output logic [1:0] a,
                                  output logic [15:0] w);
    logic [15:0] lim;
    lim = (ms > MaxSleepLimit) ? MaxSleepLimit : ((ms == 16'd0) ? 16'd1 : ms);
    if (h >= NoId) begin
      a = WakeStop; w = '0;
    end else if (s_less({16'd0, lim}, v)) begin
      a = WakeSet; w = lim;
    end else if (v == 32'd0 || v[31]) begin
      a = WakeFire; w = '0;
    end else begin
      a = WakeSet; w = v[15:0];
    end
  endfunction

  logic            id_running;
  logic [IdW-1:0]  dq_nxt, dq_prv, new_head;
  logic [1:0]      dq_a;
  logic [15:0]     dq_w;
  logic            nxt_valid;

  assign id_running = (status_q[idx] == StRunning);
  assign dq_nxt = next_q[idx];
  assign dq_prv = prev_q[idx];
  assign new_head = (dq_nxt < NoId) ? dq_nxt : NoId;
  assign nxt_valid = cur_valid && s_less(left_q[cur_ix], left_q[idx]);

  always_comb begin
    wake_of(new_head, left_q[IxW'(new_head)], max_sleep_q_i, dq_a, dq_w);
  end

  logic [1:0]  hw_a;
  logic [15:0] hw_w;
  always_comb begin
    wake_of(head_q, left_q[IxW'(head_q)], max_sleep_q_i, hw_a, hw_w);
  end

  assign sts_o.op = op_q;
  assign sts_o.id_ok = (32'(id_q) < NumTimers);
  assign sts_o.was_created = (status_q[idx] == StCreated);
  assign sts_o.walk_end = !cur_valid || (cnt_q >= WalkMax);
  assign sts_o.enq_direct = (head_q >= NoId) || s_less(left_q[idx], left_q[IxW'(head_q)]);
  assign sts_o.search_end = !nxt_valid || (cnt_q >= WalkMax);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i;
      id_q <= timer_id_i;
      tmo_q <= timeout_ms_i;
      rtc_q <= rtc_time_ms_i;
    end
    if (cmd_i.calc_elapsed) elap_q <= el_sum[15:0];
    if (cmd_i.sub_step) left_q[cur_ix] <= left_q[cur_ix] - {16'd0, elap_q};
    if (cmd_i.load_tmo) left_q[idx] <= {1'b0, tmo_q};
    if (cmd_i.deq && id_running) begin
      if (head_q == IdW'(id_q)) begin
        if (new_head < NoId) prev_q[IxW'(new_head)] <= NoId;
      end else begin
        if (dq_prv < NoId) next_q[IxW'(dq_prv)] <= dq_nxt;
        if (dq_nxt < NoId) prev_q[IxW'(dq_nxt)] <= dq_prv;
      end
    end
    if (cmd_i.enq_init) begin
      if (head_q >= NoId) begin
        next_q[idx] <= NoId;
        prev_q[idx] <= NoId;
      end else if (s_less(left_q[idx], left_q[IxW'(head_q)])) begin
        next_q[idx] <= head_q;
        prev_q[idx] <= NoId;
        prev_q[IxW'(head_q)] <= IdW'(id_q);
      end
    end
    if (cmd_i.enq_link) begin
      next_q[idx] <= cur_q;
      prev_q[idx] <= prv_q;
      if (cur_valid) prev_q[cur_ix] <= IdW'(id_q);
      next_q[IxW'(prv_q)] <= IdW'(id_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTimers; i++) status_q[i] <= StFree;
      head_q <= NoId;
      last_q <= '0;
      ok_q <= 1'b0;
      alloc_q <= NoId;
      wact_q <= WakeNone;
      wms_q <= '0;
      cur_q <= NoId;
      prv_q <= NoId;
      cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        ok_q <= 1'b0;
        alloc_q <= NoId;
        wact_q <= WakeNone;
        wms_q <= '0;
      end
      if (cmd_i.create && free_found) begin
        status_q[free_ix] <= StCreated;
        alloc_q <= IdW'(free_ix);
        ok_q <= 1'b1;
      end
      if (op_q == OpSync && cmd_i.calc_elapsed) ok_q <= 1'b1;
      if (cmd_i.deq) begin
        ok_q <= 1'b1;
        if (cmd_i.set_free) status_q[idx] <= StFree;
        else if (id_running) status_q[idx] <= StCreated;
        if (id_running && head_q == IdW'(id_q)) begin
          head_q <= new_head;
          wact_q <= dq_a;
          wms_q <= dq_w;
        end
      end
      if (cmd_i.calc_elapsed) last_q <= rtc_q;
      if (cmd_i.walk_init) begin
        cur_q <= head_q;
        cnt_q <= '0;
      end
      if (cmd_i.sub_step) begin
        cur_q <= next_q[cur_ix];
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.enq_init) begin
        status_q[idx] <= StRunning;
        if (sts_o.enq_direct) begin
          head_q <= IdW'(id_q);
        end else begin
          prv_q <= head_q;
          cur_q <= next_q[IxW'(head_q)];
          cnt_q <= '0;
        end
      end
      if (cmd_i.enq_step) begin
        prv_q <= cur_q;
        cur_q <= next_q[cur_ix];
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.enq_link && cur_q > NoId) cur_q <= NoId;
      if (cmd_i.wake_eval) begin
        wact_q <= hw_a;
        wms_q <= hw_w;
      end
    end
  end

  assign ok_o = ok_q;
  assign allocated_id_o = alloc_q;
  assign wake_action_o = wact_q;
  assign wake_ms_o = wms_q;
  assign head_id_o = head_q;

  a_head_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q < NoId) |-> (status_q[IxW'(head_q)] == StRunning))
    else $error("list head not running");
  a_set_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wact_q == WakeSet) |-> (wms_q <= MaxSleepLimit && wms_q != 16'd0))
    else $error("wake interval out of range");
  a_fire_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wact_q != WakeSet) |-> (wms_q == 16'd0)) else $error("stray wake interval");

endmodule

// ===== dv/sorted_timer_queue_engine_checker.sv =====
// Checker for the sorted timer queue engine: predicts each result and compares it.
`timescale 1ns / 100ps
module sorted_timer_queue_engine_checker import stq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  timer_id_i,
  input  logic [30:0] timeout_ms_i,
  input  logic [15:0] rtc_time_ms_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        done_i,
  input  logic        ok_i,
  input  logic [4:0]  allocated_id_i,
  input  logic [1:0]  wake_action_i,
  input  logic [15:0] wake_ms_i,
  input  logic [4:0]  head_id_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          wake_fire_o,
  output int          full_table_o
);

  localparam int N = 16;
  localparam logic [4:0] NoId = 5'd16;

  typedef struct packed {
    logic        ok;
    logic [4:0]  alloc;
    logic [1:0]  wake;
    logic [15:0] wake_ms;
    logic [4:0]  head;
  } timer_result_t;

  timer_result_t awaited_results[$];

  logic [1:0]  slot_st[N];
  logic [31:0] ms_left[N];
  logic [4:0]  link_nxt[N];
  logic [4:0]  link_prv[N];
  logic [4:0]  head;
  logic [15:0] last_ms;
  logic [15:0] max_sleep;
  logic [1:0]  wake_act;
  logic [15:0] wake_val;

  function automatic bit earlier(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  task automatic update_wake();
    logic [31:0] lim;
    logic [31:0] v;
    lim = {16'd0, max_sleep};
    if (lim > 32'd55000) lim = 32'd55000;
    if (lim == 32'd0) lim = 32'd1;
    if (head >= NoId) begin
      wake_act = WakeStop;
      wake_val = '0;
    end else begin
      v = ms_left[head[3:0]];
      if (earlier(lim, v)) begin
        wake_act = WakeSet;
        wake_val = lim[15:0];
      end else if (v == 32'd0 || v[31]) begin
        wake_act = WakeFire;
        wake_val = '0;
      end else begin
        wake_act = WakeSet;
        wake_val = v[15:0];
      end
    end
  endtask

  task automatic age_timers(logic [15:0] now);
    logic [15:0] elapsed;
    logic [4:0]  cur;
    int          n;
    if (last_ms <= now) elapsed = now - last_ms;
    else elapsed = 16'(32'(now) + 32'd60000 - 32'(last_ms));
    last_ms = now;
    cur = head;
    for (n = 0; n < N && cur < NoId; n++) begin
      ms_left[cur[3:0]] = ms_left[cur[3:0]] - {16'd0, elapsed};
      cur = link_nxt[cur[3:0]];
    end
  endtask

  task automatic link_in(logic [3:0] id);
    logic [4:0] p;
    logic [4:0] q;
    int         n;
    if (head >= NoId) begin
      head = {1'b0, id};
      link_nxt[id] = NoId;
      link_prv[id] = NoId;
      update_wake();
    end else if (earlier(ms_left[id], ms_left[head[3:0]])) begin
      link_nxt[id] = head;
      link_prv[id] = NoId;
      link_prv[head[3:0]] = {1'b0, id};
      head = {1'b0, id};
      update_wake();
    end else begin
      p = head;
      q = link_nxt[head[3:0]];
      for (n = 0; n < N && q < NoId && earlier(ms_left[q[3:0]], ms_left[id]); n++) begin
        p = q;
        q = link_nxt[q[3:0]];
      end
      if (q > NoId) q = NoId;
      link_nxt[id] = q;
      link_prv[id] = p;
      if (q < NoId) link_prv[q[3:0]] = {1'b0, id};
      link_nxt[p[3:0]] = {1'b0, id};
    end
    slot_st[id] = StRunning;
  endtask

  task automatic unlink(logic [3:0] id);
    logic [4:0] p;
    logic [4:0] q;
    if (slot_st[id] == StRunning) begin
      if (head == {1'b0, id}) begin
        q = link_nxt[id];
        head = (q < NoId) ? q : NoId;
        if (head < NoId) link_prv[head[3:0]] = NoId;
        update_wake();
      end else begin
        p = link_prv[id];
        q = link_nxt[id];
        if (p < NoId) link_nxt[p[3:0]] = q;
        if (q < NoId) link_prv[q[3:0]] = p;
      end
      slot_st[id] = StCreated;
    end
  endtask

  task automatic predict_timer_op(logic [2:0] op, logic [3:0] id, logic [30:0] tmo,
                                  logic [15:0] rtc);
    timer_result_t r;
    int            i;
    r.ok = 1'b0;
    r.alloc = NoId;
    wake_act = WakeNone;
    wake_val = '0;
    if (op == OpCreate) begin
      for (i = 0; i < N; i++) begin
        if (slot_st[i] == StFree) begin
          slot_st[i] = StCreated;
          r.alloc = 5'(i);
          r.ok = 1'b1;
          break;
        end
      end
      if (!r.ok) full_table_o++;
    end else if (op == OpSync) begin
      age_timers(rtc);
      r.ok = 1'b1;
    end else if (op == OpRemove || op == OpStart || op == OpStop) begin
      unlink(id);
      if (op == OpRemove) begin
        slot_st[id] = StFree;
      end else if (op == OpStart) begin
        age_timers(rtc);
        ms_left[id] = {1'b0, tmo};
        if (slot_st[id] == StCreated) link_in(id);
      end
      r.ok = 1'b1;
    end
    if (wake_act == WakeFire) wake_fire_o++;
    r.wake = wake_act;
    r.wake_ms = wake_val;
    r.head = head;
    awaited_results.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t e;
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        slot_st[i] = StFree;
        ms_left[i] = '0;
        link_nxt[i] = '0;
        link_prv[i] = '0;
      end
      head = NoId;
      last_ms = '0;
      max_sleep = MaxSleepReset;
      awaited_results.delete();
      fail_count_o = 0;
      results_o = 0;
      wake_fire_o = 0;
      full_table_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) max_sleep = cfg_data_i;
      if (done_i) begin
        results_o++;
        if (awaited_results.size() == 0) begin
          $error("result with nothing awaited");
          fail_count_o++;
        end else begin
          e = awaited_results.pop_front();
          if (ok_i !== e.ok) begin
            $error("ok: expected %0d, got %0d", e.ok, ok_i);
            fail_count_o++;
          end
          if (allocated_id_i !== e.alloc) begin
            $error("allocated_id: expected %0d, got %0d", e.alloc, allocated_id_i);
            fail_count_o++;
          end
          if (wake_action_i !== e.wake) begin
            $error("wake_action: expected %0d, got %0d", e.wake, wake_action_i);
            fail_count_o++;
          end
          if (wake_ms_i !== e.wake_ms) begin
            $error("wake_ms: expected %0d, got %0d", e.wake_ms, wake_ms_i);
            fail_count_o++;
          end
          if (head_id_i !== e.head) begin
            $error("head_id: expected %0d, got %0d", e.head, head_id_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i)
        predict_timer_op(operation_i, timer_id_i, timeout_ms_i, rtc_time_ms_i);
    end
    pending_o = awaited_results.size();
  end

endmodule

// ===== dv/sorted_timer_queue_engine_test.sv =====
// Testbench top: drives timer operations and register writes, gives the verdict.
`timescale 1ns / 100ps
module sorted_timer_queue_engine_test;
  import stq_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  operation_i = OpCreate;
  logic [3:0]  timer_id_i = '0;
  logic [30:0] timeout_ms_i = '0;
  logic [15:0] rtc_time_ms_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        done_o;
  logic        ok_o;
  logic [4:0]  allocated_id_o;
  logic [1:0]  wake_action_o;
  logic [15:0] wake_ms_o;
  logic [4:0]  head_id_o;
  int          fail_count;
  int          pending;
  int          results;
  int          wake_fires;
  int          full_tables;
  int          cycles = 0;
  int          items_sent = 0;
  logic [15:0] rtc_now = '0;
  bit          gaps_on = 1'b1;
  int          gap_burst = 0;

  localparam int CycleLimit = 600000;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sorted_timer_queue_engine dut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .timer_id_i, .timeout_ms_i,
    .rtc_time_ms_i, .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .done_o, .ok_o,
    .allocated_id_o, .wake_action_o, .wake_ms_o, .head_id_o
  );

  sorted_timer_queue_engine_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .operation_i, .timer_id_i,
    .timeout_ms_i, .rtc_time_ms_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_data_i, .done_i(done_o), .ok_i(ok_o), .allocated_id_i(allocated_id_o),
    .wake_action_i(wake_action_o), .wake_ms_i(wake_ms_o), .head_id_i(head_id_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results),
    .wake_fire_o(wake_fires), .full_table_o(full_tables)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("sorted_timer_queue_engine_test: done, errors");
      $finish;
    end
  end

  task automatic send_timer_op(logic [2:0] op, logic [3:0] id, logic [30:0] tmo,
                               logic [15:0] rtc);
    int gap;
    if (gaps_on) begin
      if (gap_burst > 0) begin
        gap_burst--;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 14);
        repeat (gap) @(negedge clk_i);
      end else if ($urandom_range(0, 9) == 0) begin
        gap_burst = $urandom_range(10, 40);
      end
    end
    while (busy) @(negedge clk_i);
    operation_i = op;
    timer_id_i = id;
    timeout_ms_i = tmo;
    rtc_time_ms_i = rtc;
    start = 1'b1;
    @(negedge clk_i);
    start = 1'b0;
    items_sent++;
  endtask

  task automatic write_max_sleep(logic [15:0] value);
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_data_i = value;
    cfg_valid_i = 1'b1;
    while (!cfg_ready_o) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [30:0] pick_timeout();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom);
      3, 4: return 31'($urandom_range(1, 70000));
      default: return 31'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [15:0] next_rtc();
    case ($urandom_range(0, 19))
      0: return 16'($urandom_range(60000, 65535));
      1: return 16'($urandom_range(0, 59999));
      default: return 16'((32'(rtc_now) + $urandom_range(0, 2500)) % 60000);
    endcase
  endfunction

  task automatic random_timer_op();
    int          pick;
    logic [2:0]  op;
    logic [15:0] rtc;
    pick = $urandom_range(0, 99);
    if (pick < 15) op = OpCreate;
    else if (pick < 45) op = OpStart;
    else if (pick < 57) op = OpStop;
    else if (pick < 65) op = OpRemove;
    else if (pick < 95) op = OpSync;
    else op = 3'($urandom_range(5, 7));
    rtc = next_rtc();
    if (op == OpStart || op == OpSync) rtc_now = rtc;
    send_timer_op(op, 4'($urandom_range(0, 15)), pick_timeout(), rtc);
  endtask

  initial begin
    logic [15:0] sleep_settings[6];
    sleep_settings = '{16'd1, 16'd0, 16'd65535, 16'd100, 16'd55000, 16'd2000};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_timer_op(OpCreate, 4'd0, '0, '0);
    send_timer_op(OpCreate, 4'd0, '0, '0);
    send_timer_op(OpStart, 4'd0, '0, 16'd10);
    send_timer_op(OpStart, 4'd1, 31'h7FFF_FFFF, 16'd20);
    send_timer_op(OpSync, 4'd0, '0, 16'd59999);
    send_timer_op(OpSync, 4'd0, '0, 16'd5);
    send_timer_op(OpSync, 4'd0, '0, 16'hFFFF);
    send_timer_op(OpSync, 4'd0, '0, 16'd100);
    send_timer_op(OpStop, 4'd0, '0, '0);
    send_timer_op(OpStop, 4'd0, '0, '0);
    send_timer_op(OpStart, 4'd7, 31'd500, 16'd200);
    send_timer_op(OpStart, 4'd0, 31'd1000, 16'd300);
    send_timer_op(OpRemove, 4'd1, '0, '0);
    send_timer_op(OpRemove, 4'd0, '0, '0);
    send_timer_op(OpRemove, 4'd15, '0, '0);
    send_timer_op(3'd5, 4'd15, 31'h5555_5555, 16'hAAAA);
    send_timer_op(3'd6, 4'd0, '0, '0);
    send_timer_op(3'd7, 4'd0, '0, '0);
    rtc_now = 16'd300;

    foreach (sleep_settings[k]) begin
      write_max_sleep(sleep_settings[k]);
      repeat (170) random_timer_op();
    end
    write_max_sleep(16'($urandom_range(1, 55000)));
    gaps_on = 1'b0;
    repeat (200) random_timer_op();

    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("Issued %0d timer operations, checked %0d results across %0d sleep limits.",
             items_sent, results, 7);
    $display("Seen %0d fire-now wake-ups and %0d creates on a full table.",
             wake_fires, full_tables);
    if (fail_count == 0) begin
      $display("sorted_timer_queue_engine_test: done, clean");
    end else begin
      $display("sorted_timer_queue_engine_test: done, errors");
    end
    $finish;
  end

endmodule
